[sv/rtt_pkg.sv]
// Package for the reference trim tracker: command codes, code-field constants,
// band limits and the reciprocal constants for the start mapping.
// No dependencies.
package rtt_pkg;

    // command carried in the input word
    typedef enum logic {
        CMD_START = 1'b0,
        CMD_MEAS  = 1'b1
    } cmd_t;

    // trim code layout: bit 7 = below midpoint, 6..3 coarse, 2..0 fine
    localparam int unsigned CODE_W   = 8;
    localparam int unsigned LEVEL_W  = 14;
    localparam int unsigned MEAS_W   = 16;

    localparam logic [CODE_W-1:0] CODE_NEG_ZERO = 8'h80;
    localparam logic [CODE_W-1:0] CODE_COARSE_STEP = 8'h08;
    localparam logic [2:0]        FINE_MAX = 3'h7;

    // band limits in 0.1 mV units
    localparam logic [LEVEL_W-1:0] LVL_HIGH_BAND = 14'd5500;
    localparam logic [LEVEL_W-1:0] LVL_LOW_BAND  = 14'd4500;
    localparam logic [LEVEL_W-1:0] LVL_MID       = 14'd5000;

    // coarse bands start at this coarse index
    localparam logic [4:0] COARSE_OFFSET = 5'd10;

    // reciprocals: floor(d/500) = (d*RECIP_500) >> SHIFT_500, exact for 14-bit d
    localparam int unsigned  SHIFT_500 = 23;
    localparam logic [14:0]  RECIP_500 = 15'd16778;
    // floor(d/50) = (d*RECIP_50) >> SHIFT_50, exact for 14-bit d
    localparam int unsigned  SHIFT_50  = 19;
    localparam logic [13:0]  RECIP_50  = 14'd10486;

endpackage

[sv/reference_trim_tracker.sv]
// Reference trim tracker: start mapping, up/down code stepping and reversal detect.
// Depends on rtt_pkg.
// Output: a result word is registered and appears in the cycle after its input word is accepted.
// Throughput: one word per cycle; s_tready is low only while a result is held
// and m_tready is low. The datapath is one reciprocal multiply or one compare
// and code step between the tracker state and the result register.
// Reset: aresetn, synchronous and active low, clears all tracker state and m_tvalid.
module reference_trim_tracker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // target_level[13:0], measured_level[29:14], zero fill
    input  logic [1:0]  s_tuser,   // cmd[0], channel_sel[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // trim_code[7:0], final_level[23:8]
    output logic [1:0]  m_tuser,   // code_written[0], ref_channel[1]
    output logic        m_tlast    // finished
);
    import rtt_pkg::*;

    // tracker state
    logic [CODE_W-1:0]  applied_code_reg, applied_code_next;
    logic [LEVEL_W-1:0] goal_level_reg, goal_level_next;
    logic               was_high_reg, was_high_next;
    logic               was_low_reg, was_low_next;
    logic               active_channel_reg, active_channel_next;
    logic               running_reg, running_next;

    // result register
    logic               out_valid_reg;
    logic [CODE_W-1:0]  out_code_reg, out_code_next;
    logic               out_written_reg, out_written_next;
    logic               out_channel_reg, out_channel_next;
    logic               out_finished_reg, out_finished_next;
    logic [MEAS_W-1:0]  out_final_reg, out_final_next;

    logic               in_accept;
    cmd_t               in_cmd;
    logic               in_chan;
    logic [LEVEL_W-1:0] in_target;
    logic [MEAS_W-1:0]  in_meas;

    // start mapping
    logic               band_coarse;
    logic               band_neg;
    logic [LEVEL_W-1:0] band_diff;
    logic [28:0]        prod_500;
    logic [27:0]        prod_50;
    logic [4:0]         coarse_idx;
    logic [CODE_W-1:0]  start_code;

    // stepping
    logic               meas_high;
    logic [2:0]         fine_up, fine_dn;
    logic [CODE_W-1:0]  base_up, base_dn;
    logic [CODE_W-1:0]  code_up, code_dn, step_code;
    logic               reversal;

    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign in_cmd    = cmd_t'(s_tuser[0]);
    assign in_chan   = s_tuser[1];
    assign in_target = s_tdata[13:0];
    assign in_meas   = s_tdata[29:14];

    // pick the band and the distance from its edge
    always_comb begin
        priority if (in_target > LVL_HIGH_BAND) begin
            band_coarse = 1'b1;
            band_neg    = 1'b0;
            band_diff   = in_target - LVL_HIGH_BAND;
        end else if (in_target < LVL_LOW_BAND) begin
            band_coarse = 1'b1;
            band_neg    = 1'b1;
            band_diff   = LVL_LOW_BAND - in_target;
        end else if (in_target >= LVL_MID) begin
            band_coarse = 1'b0;
            band_neg    = 1'b0;
            band_diff   = in_target - LVL_MID;
        end else begin
            band_coarse = 1'b0;
            band_neg    = 1'b1;
            band_diff   = LVL_MID - in_target;
        end
    end

    // divide by 500 or 50 through reciprocal multiplies, keep index mod 32
    assign prod_500 = {15'd0, band_diff} * {14'd0, RECIP_500};
    assign prod_50  = {14'd0, band_diff} * {14'd0, RECIP_50};

    always_comb begin
        if (band_coarse) begin
            coarse_idx = prod_500[SHIFT_500 +: 5] + COARSE_OFFSET;
        end else begin
            coarse_idx = prod_50[SHIFT_50 +: 5];
        end
        start_code = {coarse_idx[4] ^ band_neg, coarse_idx[3:0], 3'b000};
    end

    // step up: fine wraps into the coarse part following the sign
    always_comb begin
        fine_up = applied_code_reg[2:0] + 3'd1;
        base_up = {applied_code_reg[7:3], 3'b000};
        if (fine_up != 3'd0) begin
            code_up = {applied_code_reg[7:3], fine_up};
        end else if (base_up == CODE_NEG_ZERO) begin
            code_up = '0;
        end else if (!base_up[7]) begin
            code_up = base_up + CODE_COARSE_STEP;
        end else begin
            code_up = base_up - CODE_COARSE_STEP;
        end
    end

    // step down: fine borrow moves the coarse part the other way
    always_comb begin
        fine_dn = applied_code_reg[2:0] - 3'd1;
        base_dn = {applied_code_reg[7:3], fine_dn};
        if (fine_dn != FINE_MAX) begin
            code_dn = base_dn;
        end else if (!base_dn[7]) begin
            code_dn = base_dn - CODE_COARSE_STEP;
        end else begin
            code_dn = base_dn + CODE_COARSE_STEP;
        end
    end

    assign meas_high = {2'b00, goal_level_reg} < in_meas;
    assign step_code = meas_high ? code_dn : code_up;
    assign reversal  = (meas_high && was_low_reg) || (!meas_high && was_high_reg);

    // next state and result for the word at the input
    always_comb begin
        applied_code_next   = applied_code_reg;
        goal_level_next     = goal_level_reg;
        was_high_next       = was_high_reg;
        was_low_next        = was_low_reg;
        active_channel_next = active_channel_reg;
        running_next        = running_reg;
        out_written_next    = 1'b0;
        out_finished_next   = 1'b0;
        out_final_next      = '0;
        unique case (in_cmd)
            CMD_START: begin
                applied_code_next   = start_code;
                goal_level_next     = in_target;
                active_channel_next = in_chan;
                was_high_next       = 1'b0;
                was_low_next        = 1'b0;
                running_next        = 1'b1;
                out_written_next    = 1'b1;
            end
            CMD_MEAS: begin
                if (running_reg) begin
                    if (reversal) begin
                        out_finished_next = 1'b1;
                        out_final_next    = in_meas;
                        running_next      = 1'b0;
                    end else begin
                        applied_code_next = step_code;
                        was_high_next     = meas_high;
                        was_low_next      = !meas_high;
                        out_written_next  = 1'b1;
                    end
                end
            end
            default: begin
                running_next = running_reg;
            end
        endcase
        out_code_next    = applied_code_next;
        out_channel_next = active_channel_next;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            applied_code_reg   <= '0;
            goal_level_reg     <= '0;
            was_high_reg       <= 1'b0;
            was_low_reg        <= 1'b0;
            active_channel_reg <= 1'b0;
            running_reg        <= 1'b0;
            out_valid_reg      <= 1'b0;
        end else begin
            if (in_accept) begin
                applied_code_reg   <= applied_code_next;
                goal_level_reg     <= goal_level_next;
                was_high_reg       <= was_high_next;
                was_low_reg        <= was_low_next;
                active_channel_reg <= active_channel_next;
                running_reg        <= running_next;
                out_valid_reg      <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            out_code_reg     <= out_code_next;
            out_written_reg  <= out_written_next;
            out_channel_reg  <= out_channel_next;
            out_finished_reg <= out_finished_next;
            out_final_reg    <= out_final_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_final_reg, out_code_reg};
    assign m_tuser  = {out_channel_reg, out_written_reg};
    assign m_tlast  = out_finished_reg;

`ifndef NO_ASSERTIONS
    // a run never ends with a code write
    a_done_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> !m_tuser[0])
        else $error("finished word also reports a code write");

    // final level is zero unless the run ended
    a_final_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[23:8] == '0))
        else $error("final level set on a word that did not end the run");

    // an accepted start yields a written code and a running tracker
    a_start_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && (in_cmd == CMD_START)) |=> (m_tvalid && m_tuser[0] && running_reg))
        else $error("start word did not arm the tracker");

    // direction history is never both high and low
    a_dir_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(was_high_reg && was_low_reg))
        else $error("direction history holds both directions");
`endif

endmodule

[bench/trim_result_checker.sv]
// Result checker for the reference trim tracker: watches both stream channels,
// predicts each result word from the accepted input words and compares them.
// Depends on rtt_pkg.
`timescale 1ns / 100ps

module trim_result_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // target_level[13:0], measured_level[29:14], zero fill
    input  logic [1:0]  s_tuser,   // cmd[0], channel_sel[1]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // trim_code[7:0], final_level[23:8]
    input  logic [1:0]  m_tuser,   // code_written[0], ref_channel[1]
    input  logic        m_tlast,   // finished
    output int          fail_count,
    output int          outstanding,
    output int          words_in,
    output int          results_seen,
    output int          runs_ended
);
    import rtt_pkg::*;

    localparam int unsigned COARSE_SPAN = 500;
    localparam int unsigned FINE_SPAN   = 50;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              written;
        logic              channel;
        logic              finished;
        logic [MEAS_W-1:0] final_level;
    } trim_result_t;

    // tracker state as the predictor sees it
    logic [CODE_W-1:0]  applied_code;
    logic [LEVEL_W-1:0] goal_level;
    logic               went_high;
    logic               went_low;
    logic               trim_channel;
    logic               trimming;

    trim_result_t pending_results[$];

    // per-word scratch
    trim_result_t       want;
    trim_result_t       next_result;
    cmd_t               word_cmd;
    logic [LEVEL_W-1:0] word_target;
    logic [MEAS_W-1:0]  word_meas;
    logic               meas_high;

    // initial code for a target level, band by band, wrapping at 8 bits
    function automatic logic [CODE_W-1:0] initial_code(input logic [LEVEL_W-1:0] target);
        int unsigned t;
        int unsigned c;
        t = target;
        if (t > LVL_HIGH_BAND)
            c = ((t - LVL_HIGH_BAND) / COARSE_SPAN + COARSE_OFFSET) * 8;
        else if (t < LVL_LOW_BAND)
            c = ((LVL_LOW_BAND - t) / COARSE_SPAN + COARSE_OFFSET) * 8 + CODE_NEG_ZERO;
        else if (t >= LVL_MID)
            c = ((t - LVL_MID) / FINE_SPAN) * 8;
        else
            c = ((LVL_MID - t) / FINE_SPAN) * 8 + CODE_NEG_ZERO;
        return c[CODE_W-1:0];
    endfunction

    // one fine step up; the coarse carry follows the sign bit
    function automatic logic [CODE_W-1:0] code_up(input logic [CODE_W-1:0] x);
        logic [CODE_W-1:0] c;
        c = {x[7:3], x[2:0] + 3'd1};
        if (c[2:0] != 3'd0)
            return c;
        if (c == CODE_NEG_ZERO)
            return '0;
        return c[7] ? c - CODE_COARSE_STEP : c + CODE_COARSE_STEP;
    endfunction

    // one fine step down; below zero the code simply wraps
    function automatic logic [CODE_W-1:0] code_down(input logic [CODE_W-1:0] x);
        logic [CODE_W-1:0] c;
        c = {x[7:3], x[2:0] - 3'd1};
        if (c[2:0] != FINE_MAX)
            return c;
        return c[7] ? c + CODE_COARSE_STEP : c - CODE_COARSE_STEP;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            applied_code = '0;
            goal_level   = '0;
            went_high    = 1'b0;
            went_low     = 1'b0;
            trim_channel = 1'b0;
            trimming     = 1'b0;
            pending_results.delete();
            fail_count   = 0;
            words_in     = 0;
            results_seen = 0;
            runs_ended   = 0;
        end else begin
            // result word leaving the block: compare with the oldest prediction
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    $error("result word with nothing pending: trim_code %0h", m_tdata[7:0]);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_tdata[7:0] !== want.code) begin
                        $error("trim_code: expected %0h, got %0h", want.code, m_tdata[7:0]);
                        fail_count++;
                    end
                    if (m_tuser[0] !== want.written) begin
                        $error("code_written: expected %0b, got %0b", want.written, m_tuser[0]);
                        fail_count++;
                    end
                    if (m_tuser[1] !== want.channel) begin
                        $error("ref_channel: expected %0b, got %0b", want.channel, m_tuser[1]);
                        fail_count++;
                    end
                    if (m_tlast !== want.finished) begin
                        $error("finished: expected %0b, got %0b", want.finished, m_tlast);
                        fail_count++;
                    end
                    if (m_tdata[23:8] !== want.final_level) begin
                        $error("final_level: expected %0d, got %0d",
                               want.final_level, m_tdata[23:8]);
                        fail_count++;
                    end
                end
            end

            // input word entering the block: advance the tracker and predict
            if (s_tvalid && s_tready) begin
                words_in++;
                word_cmd    = cmd_t'(s_tuser[0]);
                word_target = s_tdata[13:0];
                word_meas   = s_tdata[29:14];
                next_result = '0;
                if (word_cmd == CMD_START) begin
                    applied_code = initial_code(word_target);
                    goal_level   = word_target;
                    trim_channel = s_tuser[1];
                    went_high    = 1'b0;
                    went_low     = 1'b0;
                    trimming     = 1'b1;
                    next_result.written = 1'b1;
                end else if (trimming) begin
                    meas_high = word_meas > {2'b00, goal_level};
                    if ((meas_high && went_low) || (!meas_high && went_high)) begin
                        // direction reversal closes the run
                        next_result.finished    = 1'b1;
                        next_result.final_level = word_meas;
                        trimming = 1'b0;
                        runs_ended++;
                    end else begin
                        applied_code = meas_high ? code_down(applied_code)
                                                 : code_up(applied_code);
                        went_high = meas_high;
                        went_low  = !meas_high;
                        next_result.written = 1'b1;
                    end
                end
                next_result.code    = applied_code;
                next_result.channel = trim_channel;
                pending_results.push_back(next_result);
            end
        end
        outstanding <= pending_results.size();
    end

endmodule

[bench/tb_reference_trim_tracker.sv]
// Testbench top for the reference trim tracker: clock, reset, stimulus and verdict.
// Depends on rtt_pkg, reference_trim_tracker and trim_result_checker.
`timescale 1ns / 100ps

module tb_reference_trim_tracker;
    import rtt_pkg::*;

    localparam int RANDOM_WORDS = 1450;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 64;
    localparam int PAUSE_AT     = 900;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // target_level[13:0], measured_level[29:14], zero fill
    logic [1:0]  s_tuser;   // cmd[0], channel_sel[1]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // trim_code[7:0], final_level[23:8]
    logic [1:0]  m_tuser;   // code_written[0], ref_channel[1]
    logic        m_tlast;   // finished

    int fail_count;
    int outstanding;
    int words_in;
    int results_seen;
    int runs_ended;

    int words_sent = 0;
    int trim_words = 0;
    int cycle_count = 0;
    bit quiet = 1'b0;
    bit paused = 1'b0;

    logic [LEVEL_W-1:0] band_edges [8] = '{14'd0, 14'd16383, 14'd1600, 14'd8400,
                                          14'd4500, 14'd4499, 14'd5500, 14'd5501};

    reference_trim_tracker dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    trim_result_checker u_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .words_in     (words_in),
        .results_seen (results_seen),
        .runs_ended   (runs_ended)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // run length guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // result side: random stalls, one long hold-off while the sender keeps going
    initial begin : result_sink
        bit held;
        held = 1'b0;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (!held && words_sent >= HOLD_AT) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 9);
            end
        end
    end

    // offer one word, with an occasional idle gap, and wait for its handshake
    task automatic put_word(input cmd_t cmd, input logic chan,
                            input logic [LEVEL_W-1:0] target, input logic [MEAS_W-1:0] meas);
        if (!quiet && $urandom_range(0, 99) < 9) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {chan, cmd};
        s_tdata  <= {2'b00, meas, target};
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    // measurement on one side of the goal, often close to it
    function automatic logic [MEAS_W-1:0] pick_meas(input logic [LEVEL_W-1:0] goal,
                                                    input bit high);
        int unsigned g;
        int unsigned lo_v;
        int unsigned hi_v;
        g = goal;
        if (high) begin
            lo_v = g + 1;
            hi_v = ($urandom_range(0, 2) == 0) ? g + 20 : 65535;
        end else begin
            hi_v = g;
            lo_v = ($urandom_range(0, 2) == 0 && g >= 20) ? g - 20 : 0;
        end
        return MEAS_W'($urandom_range(hi_v, lo_v));
    endfunction

    // start, a stretch of same-side measurements, then usually a reversal
    task automatic trim_run();
        logic [LEVEL_W-1:0] target;
        bit                 high;
        int                 steps;
        target = ($urandom_range(0, 9) == 0) ? LEVEL_W'($urandom_range(0, 16383))
                                             : LEVEL_W'($urandom_range(1600, 8400));
        put_word(CMD_START, 1'($urandom), target, MEAS_W'($urandom));
        trim_words++;
        high  = 1'($urandom_range(0, 1));
        steps = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 8);
        repeat (steps) begin
            put_word(CMD_MEAS, 1'($urandom), LEVEL_W'($urandom), pick_meas(target, high));
            trim_words++;
        end
        if ($urandom_range(0, 4) != 0) begin
            put_word(CMD_MEAS, 1'($urandom), LEVEL_W'($urandom), pick_meas(target, !high));
            trim_words++;
        end
    endtask

    initial begin : stimulus
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // measurement before any run is ignored
        put_word(CMD_MEAS, 1'b0, 14'd0, 16'hFFFF);
        // zero code stepping down wraps to all ones, then a reversal
        put_word(CMD_START, 1'b1, 14'd5000, 16'd0);
        put_word(CMD_MEAS, 1'b1, 14'h3FFF, 16'hFFFF);
        put_word(CMD_MEAS, 1'b0, 14'd0, 16'd0);
        // negative zero stepping up through the fine part into plain zero
        put_word(CMD_START, 1'b0, 14'd4999, 16'hFFFF);
        repeat (8) put_word(CMD_MEAS, 1'b0, 14'd0, 16'd4999);
        put_word(CMD_MEAS, 1'b1, 14'd0, 16'hFFFF);
        put_word(CMD_MEAS, 1'b0, 14'd0, 16'd0);
        // band edges and out-of-range targets, each restarting the run
        foreach (band_edges[i])
            put_word(CMD_START, 1'(i), band_edges[i], 16'd0);
        put_word(CMD_MEAS, 1'b0, 14'd0, 16'd5502);

        // random runs with some noise in between
        while (trim_words < RANDOM_WORDS) begin
            quiet = trim_words >= 500 && trim_words < 700;
            if (!paused && trim_words >= PAUSE_AT) begin
                paused = 1'b1;
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (outstanding != 0);
            end
            if ($urandom_range(0, 99) < 85) begin
                trim_run();
            end else if ($urandom_range(0, 1) == 0) begin
                put_word(CMD_MEAS, 1'($urandom), LEVEL_W'($urandom), MEAS_W'($urandom));
            end else begin
                put_word(CMD_START, 1'($urandom), LEVEL_W'($urandom), MEAS_W'($urandom));
                trim_words++;
            end
        end
        quiet = 1'b0;

        // drain and let the output register settle
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (4) @(posedge aclk);

        $display("sent %0d input words, checked %0d result words", words_in, results_seen);
        $display("%0d trim runs closed by a direction reversal", runs_ended);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
